[src/chm_pkg.sv]
package chm_pkg;

  localparam int POOL_ENTRIES     = 1024;
  localparam int MAX_BUCKET_BITS  = 10;
  localparam int INIT_BUCKET_BITS = 2;
  localparam int GROW_BITS        = 2;
  localparam int CHAIN_LIMIT      = 3;

  localparam int NODE_W  = $clog2(POOL_ENTRIES + 1);   // node index incl. null
  localparam int NADDR_W = $clog2(POOL_ENTRIES);
  localparam int BKT_W   = MAX_BUCKET_BITS;
  localparam int BKT_N   = 1 << MAX_BUCKET_BITS;
  localparam int BITS_W  = $clog2(MAX_BUCKET_BITS + 1);
  localparam int CNT_W   = $clog2(BKT_N + 1);
  localparam int THR_W   = MAX_BUCKET_BITS + 5;

  localparam logic [31:0] HASH_MULT = 32'd2654435761;
  localparam logic [NODE_W-1:0] NIL_NODE = NODE_W'(POOL_ENTRIES);

  typedef enum logic [1:0] {
    CMD_GET = 2'd0,
    CMD_SET = 2'd1,
    CMD_DEL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_RO     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HASH, S_HEAD, S_WALK, S_CMP, S_DEL, S_ALLOC, S_INS,
    S_GCLR, S_GBKT, S_GHEAD, S_GNODE, S_GIDX, S_GPUSH, S_DONE
  } state_t;

  // Fold a stored hash to a bucket index for a table of 2^bits buckets.
  function automatic logic [BKT_W-1:0] bucket_of(logic [31:0] h, logic [BITS_W-1:0] bits);
    logic [31:0] s;
    logic [31:0] m;
    s = h + (h >> (32'd32 - 32'(bits)));
    m = (32'd1 << bits) - 32'd1;
    return BKT_W'(s & m);
  endfunction

endpackage

[src/chm_ram.sv]
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/chm_hash.sv]
module chm_hash (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] key,
  output logic [31:0] hash_r
);

  logic [31:0] hash_nxt;

  // Only the low 32 bits of the shifted key reach the low half of the product.
  assign hash_nxt = key[34:3] * chm_pkg::HASH_MULT;

  always_ff @(posedge clk) begin
    if (en) begin
      hash_r <= hash_nxt;
    end
  end

endmodule

[src/chained_hash_map_engine.sv]
// A lookup walks its bucket's chain node by node and answers on a hit or at the chain end;
// a delete hit adds a free-list step, an insert adds a write step (and a free-list pop when
// it reuses a node), and a no-op or a read-only reject skips the walk.
// Throughput: one item at a time; in_tready is high only while the sequencer is idle.
// Growth clears the spare bank, then moves every entry of each old bucket into it.
// Reset (rst_n low, synchronous) clears control state, then 2^INIT_BUCKET_BITS buckets.
module chained_hash_map_engine (
  input  logic         clk,
  input  logic         rst_n,
  // cmd[1:0], key[65:2], value[129:66], set_mode[131:130], zero pad
  input  logic [135:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // status[1:0], value_out[65:2], entry_count[76:66], zero pad
  output logic [79:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);

  localparam int NODE_W  = chm_pkg::NODE_W;
  localparam int NADDR_W = chm_pkg::NADDR_W;
  localparam int BKT_W   = chm_pkg::BKT_W;
  localparam int BITS_W  = chm_pkg::BITS_W;
  localparam int CNT_W   = chm_pkg::CNT_W;
  localparam int THR_W   = chm_pkg::THR_W;
  localparam logic [NODE_W-1:0] NIL = chm_pkg::NIL_NODE;

  chm_pkg::state_t state_r, state_nxt;
  chm_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [63:0]       key_r, key_nxt, val_r, val_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [BKT_W-1:0]  idx_r, idx_nxt, gidx_r, gidx_nxt;
  logic [NODE_W-1:0] head_r, head_nxt, cur_r, cur_nxt, prev_r, prev_nxt;
  logic [NODE_W-1:0] e_r, e_nxt, nlink_r, nlink_nxt;
  logic [NODE_W-1:0] free_r, free_nxt, fresh_r, fresh_nxt, stored_r, stored_nxt;
  logic [BITS_W-1:0] bits_r, bits_nxt, nb_r, nb_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              sel_r, sel_nxt, ro_r, rd_bank_r;
  chm_pkg::status_t  res_st_r, res_st_nxt, out_st_r;
  logic [63:0]       res_val_r, res_val_nxt, out_val_r;
  logic [NODE_W-1:0] out_cnt_r;
  logic              out_valid_r, out_load;

  logic [31:0] hash_r;
  logic        in_acc;

  // Bucket banks: one holds the live table, the other is built during growth.
  logic             bkt_rbank, bkt_we, bkt_wbank;
  logic [BKT_W-1:0] bkt_raddr, bkt_waddr;
  logic [NODE_W-1:0] bkt_wdata, b0_rdata, b1_rdata, bkt_rdata;

  logic [NADDR_W-1:0] node_raddr;
  logic [63:0]        key_rd, value_rd;
  logic [NODE_W-1:0]  link_rd;
  logic [31:0]        hash_rd;
  logic               key_we, value_we, link_we;
  logic [NADDR_W-1:0] key_waddr, value_waddr, link_waddr;
  logic [63:0]        value_wdata;
  logic [NODE_W-1:0]  link_wdata;

  logic [BKT_W-1:0]  idx_c;
  logic [THR_W-1:0]  thr_c;
  logic [BITS_W:0]   nb_sum;
  logic [CNT_W-1:0]  new_cnt_c, old_cnt_c;

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign bkt_rdata = rd_bank_r ? b1_rdata : b0_rdata;
  assign idx_c     = chm_pkg::bucket_of(hash_r, bits_r);
  assign new_cnt_c = CNT_W'(1) << nb_r;
  assign old_cnt_c = CNT_W'(1) << bits_r;

  chm_hash u_hash (
    .clk    (clk),
    .en     (in_acc),
    .key    (in_tdata[65:2]),
    .hash_r (hash_r)
  );

  chm_ram #(.WIDTH(NODE_W), .DEPTH(chm_pkg::BKT_N)) u_bkt0 (
    .clk(clk), .we(bkt_we && !bkt_wbank), .waddr(bkt_waddr), .wdata(bkt_wdata),
    .raddr(bkt_raddr), .rdata(b0_rdata)
  );

  chm_ram #(.WIDTH(NODE_W), .DEPTH(chm_pkg::BKT_N)) u_bkt1 (
    .clk(clk), .we(bkt_we && bkt_wbank), .waddr(bkt_waddr), .wdata(bkt_wdata),
    .raddr(bkt_raddr), .rdata(b1_rdata)
  );

  // Node store: key, value, chain link and stored hash share one read address.
  chm_ram #(.WIDTH(64), .DEPTH(chm_pkg::POOL_ENTRIES)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_r),
    .raddr(node_raddr), .rdata(key_rd)
  );

  chm_ram #(.WIDTH(64), .DEPTH(chm_pkg::POOL_ENTRIES)) u_value (
    .clk(clk), .we(value_we), .waddr(value_waddr), .wdata(value_wdata),
    .raddr(node_raddr), .rdata(value_rd)
  );

  chm_ram #(.WIDTH(NODE_W), .DEPTH(chm_pkg::POOL_ENTRIES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(node_raddr), .rdata(link_rd)
  );

  chm_ram #(.WIDTH(32), .DEPTH(chm_pkg::POOL_ENTRIES)) u_nhash (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(hash_r),
    .raddr(node_raddr), .rdata(hash_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chm_pkg::S_CLR;
      cnt_r       <= '0;
      free_r      <= NIL;
      fresh_r     <= '0;
      stored_r    <= '0;
      bits_r      <= BITS_W'(chm_pkg::INIT_BUCKET_BITS);
      sel_r       <= 1'b0;
      ro_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      free_r   <= free_nxt;
      fresh_r  <= fresh_nxt;
      stored_r <= stored_nxt;
      bits_r   <= bits_nxt;
      sel_r    <= sel_nxt;
      if (cfg_valid) begin
        ro_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    mode_r    <= mode_nxt;
    idx_r     <= idx_nxt;
    gidx_r    <= gidx_nxt;
    head_r    <= head_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    e_r       <= e_nxt;
    nlink_r   <= nlink_nxt;
    nb_r      <= nb_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    rd_bank_r <= bkt_rbank;
    if (out_load) begin
      out_st_r  <= res_st_r;
      out_val_r <= res_val_r;
      out_cnt_r <= stored_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_cnt_r, out_val_r, out_st_r};

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    mode_nxt    = mode_r;
    idx_nxt     = idx_r;
    gidx_nxt    = gidx_r;
    head_nxt    = head_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    e_nxt       = e_r;
    nlink_nxt   = nlink_r;
    nb_nxt      = nb_r;
    cnt_nxt     = cnt_r;
    free_nxt    = free_r;
    fresh_nxt   = fresh_r;
    stored_nxt  = stored_r;
    bits_nxt    = bits_r;
    sel_nxt     = sel_r;
    res_st_nxt  = res_st_r;
    res_val_nxt = res_val_r;
    in_tready   = 1'b0;
    out_load    = 1'b0;
    bkt_rbank   = sel_r;
    bkt_raddr   = idx_c;
    bkt_we      = 1'b0;
    bkt_wbank   = sel_r;
    bkt_waddr   = idx_r;
    bkt_wdata   = NIL;
    node_raddr  = cur_r[NADDR_W-1:0];
    key_we      = 1'b0;
    key_waddr   = e_r[NADDR_W-1:0];
    value_we    = 1'b0;
    value_waddr = cur_r[NADDR_W-1:0];
    value_wdata = val_r;
    link_we     = 1'b0;
    link_waddr  = cur_r[NADDR_W-1:0];
    link_wdata  = link_rd;
    thr_c       = (THR_W'(1) << bits_r) * THR_W'(chm_pkg::CHAIN_LIMIT);
    nb_sum      = (BITS_W + 1)'(bits_r) + (BITS_W + 1)'(chm_pkg::GROW_BITS);

    unique case (state_r)
      chm_pkg::S_CLR: begin
        bkt_we    = 1'b1;
        bkt_wbank = 1'b0;
        bkt_waddr = cnt_r[BKT_W-1:0];
        if (cnt_r == CNT_W'((1 << chm_pkg::INIT_BUCKET_BITS) - 1)) begin
          cnt_nxt   = '0;
          state_nxt = chm_pkg::S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      chm_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt   = chm_pkg::cmd_t'(in_tdata[1:0]);
          key_nxt   = in_tdata[65:2];
          val_nxt   = in_tdata[129:66];
          mode_nxt  = in_tdata[131:130];
          state_nxt = chm_pkg::S_HASH;
        end
      end
      chm_pkg::S_HASH: begin
        idx_nxt     = idx_c;
        res_val_nxt = '0;
        if (cmd_r == chm_pkg::CMD_NOP) begin
          res_st_nxt = chm_pkg::ST_ABSENT;
          state_nxt  = chm_pkg::S_DONE;
        end else if (cmd_r != chm_pkg::CMD_GET && ro_r) begin
          res_st_nxt = chm_pkg::ST_RO;
          state_nxt  = chm_pkg::S_DONE;
        end else begin
          state_nxt = chm_pkg::S_HEAD;
        end
      end
      chm_pkg::S_HEAD: begin
        head_nxt  = bkt_rdata;
        cur_nxt   = bkt_rdata;
        prev_nxt  = NIL;
        state_nxt = chm_pkg::S_WALK;
      end
      chm_pkg::S_WALK: begin
        if (cur_r != NIL) begin
          state_nxt = chm_pkg::S_CMP;
        end else begin
          // Miss: only a set that may create goes on to allocate a node.
          res_st_nxt  = chm_pkg::ST_ABSENT;
          res_val_nxt = '0;
          state_nxt   = chm_pkg::S_DONE;
          if (cmd_r == chm_pkg::CMD_SET && !mode_r[1]) begin
            if (free_r != NIL) begin
              node_raddr = free_r[NADDR_W-1:0];
              e_nxt      = free_r;
              state_nxt  = chm_pkg::S_ALLOC;
            end else if (fresh_r != NIL) begin
              e_nxt     = fresh_r;
              fresh_nxt = fresh_r + NODE_W'(1);
              state_nxt = chm_pkg::S_INS;
            end else begin
              res_st_nxt = chm_pkg::ST_FULL;
            end
          end
        end
      end
      chm_pkg::S_CMP: begin
        if (key_rd != key_r) begin
          prev_nxt  = cur_r;
          cur_nxt   = link_rd;
          state_nxt = chm_pkg::S_WALK;
        end else begin
          state_nxt = chm_pkg::S_DONE;
          unique case (cmd_r)
            chm_pkg::CMD_SET: begin
              res_st_nxt = chm_pkg::ST_OK;
              if (value_rd == '0 || !mode_r[0]) begin
                value_we    = 1'b1;
                res_val_nxt = val_r;
              end else begin
                res_val_nxt = value_rd;
              end
            end
            chm_pkg::CMD_DEL: begin
              // Unlink here; the node goes onto the free list next cycle.
              if (prev_r != NIL) begin
                link_we    = 1'b1;
                link_waddr = prev_r[NADDR_W-1:0];
              end else begin
                bkt_we    = 1'b1;
                bkt_wdata = link_rd;
              end
              res_st_nxt  = (value_rd != '0) ? chm_pkg::ST_OK : chm_pkg::ST_ABSENT;
              res_val_nxt = value_rd;
              state_nxt   = chm_pkg::S_DEL;
            end
            default: begin
              res_st_nxt  = (value_rd != '0) ? chm_pkg::ST_OK : chm_pkg::ST_ABSENT;
              res_val_nxt = value_rd;
            end
          endcase
        end
      end
      chm_pkg::S_DEL: begin
        link_we    = 1'b1;
        link_wdata = free_r;
        free_nxt   = cur_r;
        if (stored_r != '0) begin
          stored_nxt = stored_r - NODE_W'(1);
        end
        state_nxt = chm_pkg::S_DONE;
      end
      chm_pkg::S_ALLOC: begin
        free_nxt  = link_rd;
        state_nxt = chm_pkg::S_INS;
      end
      chm_pkg::S_INS: begin
        key_we      = 1'b1;
        value_we    = 1'b1;
        value_waddr = e_r[NADDR_W-1:0];
        link_we     = 1'b1;
        link_waddr  = e_r[NADDR_W-1:0];
        link_wdata  = head_r;
        bkt_we      = 1'b1;
        bkt_wdata   = e_r;
        stored_nxt  = stored_r + NODE_W'(1);
        res_st_nxt  = chm_pkg::ST_OK;
        res_val_nxt = val_r;
        nb_nxt      = (nb_sum > (BITS_W + 1)'(chm_pkg::MAX_BUCKET_BITS))
                      ? BITS_W'(chm_pkg::MAX_BUCKET_BITS) : nb_sum[BITS_W-1:0];
        cnt_nxt     = '0;
        if (bits_r < BITS_W'(chm_pkg::MAX_BUCKET_BITS)
            && THR_W'(stored_nxt) > thr_c) begin
          state_nxt = chm_pkg::S_GCLR;
        end else begin
          state_nxt = chm_pkg::S_DONE;
        end
      end
      chm_pkg::S_GCLR: begin
        // Clear the spare bank up to the new bucket count.
        bkt_we    = 1'b1;
        bkt_wbank = !sel_r;
        bkt_waddr = cnt_r[BKT_W-1:0];
        if (cnt_r + CNT_W'(1) == new_cnt_c) begin
          cnt_nxt   = '0;
          state_nxt = chm_pkg::S_GBKT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      chm_pkg::S_GBKT: begin
        bkt_raddr = cnt_r[BKT_W-1:0];
        if (cnt_r == old_cnt_c) begin
          sel_nxt   = !sel_r;
          bits_nxt  = nb_r;
          state_nxt = chm_pkg::S_DONE;
        end else begin
          state_nxt = chm_pkg::S_GHEAD;
        end
      end
      chm_pkg::S_GHEAD: begin
        cur_nxt   = bkt_rdata;
        state_nxt = chm_pkg::S_GNODE;
      end
      chm_pkg::S_GNODE: begin
        if (cur_r == NIL) begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = chm_pkg::S_GBKT;
        end else begin
          state_nxt = chm_pkg::S_GIDX;
        end
      end
      chm_pkg::S_GIDX: begin
        nlink_nxt = link_rd;
        gidx_nxt  = chm_pkg::bucket_of(hash_rd, nb_r);
        bkt_rbank = !sel_r;
        bkt_raddr = chm_pkg::bucket_of(hash_rd, nb_r);
        state_nxt = chm_pkg::S_GPUSH;
      end
      chm_pkg::S_GPUSH: begin
        // Push the node onto the head of its chain in the new bank.
        link_we    = 1'b1;
        link_wdata = bkt_rdata;
        bkt_we     = 1'b1;
        bkt_wbank  = !sel_r;
        bkt_waddr  = gidx_r;
        bkt_wdata  = cur_r;
        cur_nxt    = nlink_r;
        state_nxt  = chm_pkg::S_GNODE;
      end
      chm_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = chm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = chm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[test/tb.sv]
// Expected-result store and map predictor for the hash map engine.
class map_scoreboard;
  localparam int NIL = chm_pkg::POOL_ENTRIES;

  bit          read_only;
  int          heads[chm_pkg::BKT_N];
  logic [63:0] keys[chm_pkg::POOL_ENTRIES];
  logic [63:0] vals[chm_pkg::POOL_ENTRIES];
  int          links[chm_pkg::POOL_ENTRIES];
  logic [31:0] hashes[chm_pkg::POOL_ENTRIES];
  int          free_head;
  int          fresh;
  int          count;
  int          bits;
  int          errors;

  chm_pkg::status_t exp_status[$];
  logic [63:0]      exp_value[$];
  logic [10:0]      exp_count[$];

  function new();
    foreach (heads[i]) heads[i] = NIL;
    free_head = NIL;
    fresh     = 0;
    count     = 0;
    bits      = chm_pkg::INIT_BUCKET_BITS;
    read_only = 0;
    errors    = 0;
  endfunction

  function int pending();
    return exp_status.size();
  endfunction

  function logic [31:0] mix(logic [63:0] key);
    logic [63:0] p;
    p = (key >> 3) * 64'd2654435761;
    return p[31:0];
  endfunction

  function int fold(logic [31:0] h, int nb);
    logic [32:0] s;
    s = {1'b0, h} + {1'b0, h >> (32 - nb)};
    return int'(s & ((33'd1 << nb) - 33'd1));
  endfunction

  // Returns the node holding key in bucket ix, or NIL; prev is its predecessor.
  function int lookup(logic [63:0] key, int ix, output int prev);
    int e;
    e = heads[ix];
    prev = NIL;
    while (e != NIL) begin
      if (keys[e] == key) return e;
      prev = e;
      e = links[e];
    end
    prev = NIL;
    return NIL;
  endfunction

  function void grow();
    int nb, e, nxt, ix;
    int fresh_heads[chm_pkg::BKT_N];
    nb = bits + chm_pkg::GROW_BITS;
    if (nb > chm_pkg::MAX_BUCKET_BITS) nb = chm_pkg::MAX_BUCKET_BITS;
    foreach (fresh_heads[i]) fresh_heads[i] = NIL;
    for (int i = 0; i < (1 << bits); i++) begin
      e = heads[i];
      while (e != NIL) begin
        nxt = links[e];
        ix = fold(hashes[e], nb);
        links[e] = fresh_heads[ix];
        fresh_heads[ix] = e;
        e = nxt;
      end
    end
    heads = fresh_heads;
    bits = nb;
  endfunction

  function void note_item(chm_pkg::cmd_t cmd, logic [63:0] key, logic [63:0] val,
                          logic [1:0] mode);
    chm_pkg::status_t st;
    logic [63:0]      vo;
    logic [31:0]      h;
    int               ix, e, prev;
    st = chm_pkg::ST_ABSENT;
    vo = '0;
    h  = mix(key);
    ix = fold(h, bits);
    case (cmd)
      chm_pkg::CMD_GET: begin
        e = lookup(key, ix, prev);
        if (e != NIL && vals[e] != 0) begin
          st = chm_pkg::ST_OK;
          vo = vals[e];
        end
      end
      chm_pkg::CMD_SET: begin
        if (read_only) begin
          st = chm_pkg::ST_RO;
        end else begin
          e = lookup(key, ix, prev);
          if (e == NIL && !mode[1]) begin
            if (free_head != NIL) begin
              e = free_head;
              free_head = links[e];
            end else if (fresh < chm_pkg::POOL_ENTRIES) begin
              e = fresh;
              fresh++;
            end
            if (e != NIL) begin
              keys[e]   = key;
              vals[e]   = '0;
              hashes[e] = h;
              links[e]  = heads[ix];
              heads[ix] = e;
              count++;
              if (bits < chm_pkg::MAX_BUCKET_BITS
                  && count > (1 << bits) * chm_pkg::CHAIN_LIMIT) grow();
            end else begin
              st = chm_pkg::ST_FULL;
            end
          end
          if (e != NIL) begin
            st = chm_pkg::ST_OK;
            if (vals[e] == 0 || !mode[0]) vals[e] = val;
            vo = vals[e];
          end
        end
      end
      chm_pkg::CMD_DEL: begin
        if (read_only) begin
          st = chm_pkg::ST_RO;
        end else begin
          e = lookup(key, ix, prev);
          if (e != NIL) begin
            if (prev != NIL) links[prev] = links[e];
            else heads[ix] = links[e];
            if (count > 0) count--;
            links[e] = free_head;
            free_head = e;
            if (vals[e] != 0) begin
              st = chm_pkg::ST_OK;
              vo = vals[e];
            end
          end
        end
      end
      default: ;
    endcase
    exp_status.push_back(st);
    exp_value.push_back(vo);
    exp_count.push_back(11'(count));
  endfunction

  function void check_result(logic [79:0] beat);
    chm_pkg::status_t st;
    logic [63:0]      vo;
    logic [10:0]      cnt;
    if (exp_status.size() == 0) begin
      $error("result beat with nothing expected: %h", beat);
      errors++;
      return;
    end
    st  = exp_status.pop_front();
    vo  = exp_value.pop_front();
    cnt = exp_count.pop_front();
    if (beat[1:0] !== st) begin
      $error("status: expected %0d, actual %0d", st, beat[1:0]);
      errors++;
    end
    if (beat[65:2] !== vo) begin
      $error("value_out: expected %h, actual %h", vo, beat[65:2]);
      errors++;
    end
    if (beat[76:66] !== cnt) begin
      $error("entry_count: expected %0d, actual %0d", cnt, beat[76:66]);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 2000000;

  logic         clk;
  logic         rst_n;
  logic [135:0] in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [79:0]  out_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_data;

  map_scoreboard sb;
  logic [63:0]   key_pool[48];
  int            cycles;
  bit            hold_request;

  chained_hash_map_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task send_item(chm_pkg::cmd_t cmd, logic [63:0] key, logic [63:0] val, logic [1:0] mode);
    int gap;
    in_tdata  <= {4'b0, mode, val, key, cmd};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(cmd, key, val, mode);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task write_read_only(bit v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.read_only = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task random_items(int n);
    chm_pkg::cmd_t cmd;
    logic [63:0]   key, val;
    int            r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      cmd = r < 35 ? chm_pkg::CMD_GET : r < 75 ? chm_pkg::CMD_SET :
            r < 95 ? chm_pkg::CMD_DEL : chm_pkg::CMD_NOP;
      key = ($urandom_range(9) == 0) ? rand_word() : key_pool[$urandom_range(47)];
      r = $urandom_range(9);
      val = r < 2 ? 64'd0 : r == 2 ? '1 : rand_word();
      send_item(cmd, key, val, 2'($urandom_range(3)));
    end
  endtask

  // Result side: random back-pressure, with one long hold-off on request.
  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_request = 0;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] base;
    sb = new();
    cycles = 0;
    hold_request = 0;
    rst_n = 1'b0;
    in_tdata = '0;
    in_tvalid = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    key_pool[0] = 64'd0;
    key_pool[1] = '1;
    for (int i = 2; i < 48; i++) key_pool[i] = rand_word();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_read_only(1'b0);
    // Directed: extremes and the awkward cases of set and delete.
    send_item(chm_pkg::CMD_GET, 64'd0, 64'd0, 2'd0);
    send_item(chm_pkg::CMD_SET, 64'd0, '1, 2'd0);
    send_item(chm_pkg::CMD_GET, 64'd0, 64'd0, 2'd0);
    send_item(chm_pkg::CMD_SET, '1, 64'd0, 2'd0);          // create holding zero
    send_item(chm_pkg::CMD_GET, '1, 64'd0, 2'd0);          // zero reads as absent
    send_item(chm_pkg::CMD_SET, '1, 64'd5, 2'd1);          // no-overwrite on zero still writes
    send_item(chm_pkg::CMD_SET, '1, 64'd9, 2'd1);          // no-overwrite keeps old value
    send_item(chm_pkg::CMD_SET, 64'h1234, 64'd7, 2'd2);    // no-create on a miss
    send_item(chm_pkg::CMD_SET, '1, 64'd11, 2'd3);
    send_item(chm_pkg::CMD_DEL, '1, 64'd0, 2'd0);
    send_item(chm_pkg::CMD_DEL, '1, 64'd0, 2'd0);          // delete miss
    send_item(chm_pkg::CMD_SET, 64'h55, 64'd0, 2'd0);
    send_item(chm_pkg::CMD_DEL, 64'h55, 64'd0, 2'd0);      // removes an entry holding zero
    send_item(chm_pkg::CMD_NOP, 64'd0, '1, 2'd3);
    for (int i = 0; i < 13; i++) begin
      send_item(chm_pkg::CMD_SET, key_pool[i + 2], rand_word(), 2'd0);
    end

    write_read_only(1'b1);
    random_items(30);
    write_read_only(1'b0);
    random_items(80);
    hold_request = 1;                              // fills the block while results wait
    random_items(40);

    // Grow the table through several steps, then free some nodes.
    write_read_only(1'b0);
    base = 64'hC0DE_0000_0000_0000;
    for (int i = 0; i < 170; i++) begin
      send_item(chm_pkg::CMD_SET, base + 64'(i) * 8, rand_word(), 2'd0);
    end
    for (int i = 0; i < 30; i++) begin
      send_item(chm_pkg::CMD_DEL, base + 64'($urandom_range(169)) * 8, 64'd0, 2'd0);
    end
    write_read_only(1'b1);
    random_items(15);
    write_read_only(1'b0);
    random_items(60);

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
